>>> src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, command and status codes, and types of the bitmap frame
// allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int MAX_FRAMES  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = MAX_FRAMES / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int FRAME_W     = 12;
    localparam int COUNT_W     = 13;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_MARK_USED = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MARK_FREE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ALLOC     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd2;

    localparam logic [APB_ADDR_W-1:0] ADDR_FRAME_COUNT = 2'd0;
    localparam logic [COUNT_W-1:0]    FRAME_COUNT_RST  = COUNT_W'(4096);

    typedef struct packed {
        logic [FRAME_W-1:0]  result_frame;
        logic                in_use;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  used_frames;
    } bfa_result_t;

    typedef struct packed {
        logic                  re;
        logic [WORD_IDX_W-1:0] raddr;
        logic                  we;
        logic [WORD_IDX_W-1:0] waddr;
        logic [WORD_BITS-1:0]  wdata;
    } bfa_ram_req_t;

    typedef struct packed {
        logic        idle;
        logic        done;
        bfa_result_t result;
    } bfa_ctrl_stat_t;

    function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

>>> src/bfa_ifs.sv
// ----------------------------------------------------------------------------
// bfa_ifs
// Valid/ready channels of the bitmap frame allocator: command words in,
// result words out.
// ----------------------------------------------------------------------------
interface bfa_cmd_if import bfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [FRAME_W-1:0] frame_index;

    modport source (output valid, output cmd, output frame_index, input ready);
    modport sink   (input valid, input cmd, input frame_index, output ready);
endinterface

interface bfa_res_if import bfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FRAME_W-1:0]  result_frame;
    logic                in_use;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  used_frames;

    modport source (output valid, output result_frame, output in_use, output status,
                    output used_frames, input ready);
    modport sink   (input valid, input result_frame, input in_use, input status,
                    input used_frames, output ready);
endinterface

>>> src/bitmap_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core
// Bitmap page-frame allocator over 4096 frame indices. One command word in
// gives one result word out. In-range mark-used, mark-free and test pass
// from acceptance to the output register through a bitmap read, a modify
// and write back, and a handoff; an out-of-range index skips the modify.
// Allocate scans the bitmap one 32-bit word per cycle from word 0 through
// the single read port of the bitmap memory, passing over up to 127 full
// words. The handoff waits while the output register holds an unaccepted
// result. One command is in flight at a time; a new command is taken while
// the previous result still waits in the output register. frame_count is
// written over the APB port at address 0; the user must write it only while
// idle; the block itself does not enforce it. Values above 4096 act as 4096.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_core import bfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bfa_cmd_if.sink               cmd_ch,
    bfa_res_if.source             res_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [COUNT_W-1:0]   frame_count_reg;
    logic [COUNT_W-1:0]   eff_count;
    logic                 cfg_wr;
    logic                 slot_free;
    logic                 res_valid_reg;
    bfa_result_t          res_data_reg;
    bfa_ram_req_t         ram_req;
    bfa_ctrl_stat_t       stat;
    logic [WORD_BITS-1:0] rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_FRAME_COUNT);
    assign prdata = (paddr == ADDR_FRAME_COUNT)
                  ? {{(APB_DATA_W - COUNT_W){1'b0}}, frame_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            frame_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign eff_count = (frame_count_reg > COUNT_W'(MAX_FRAMES))
                     ? COUNT_W'(MAX_FRAMES) : frame_count_reg;

    assign slot_free    = !res_valid_reg || res_ch.ready;
    assign cmd_ch.ready = stat.idle;

    bfa_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (cmd_ch.valid && cmd_ch.ready),
        .cmd         (cmd_ch.cmd),
        .frame_index (cmd_ch.frame_index),
        .eff_count   (eff_count),
        .slot_free   (slot_free),
        .rdata       (rdata),
        .ram_req     (ram_req),
        .stat        (stat)
    );

    bfa_bitmap_ram u_ram
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (stat.done && slot_free)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done && slot_free)
        begin
            res_data_reg <= stat.result;
        end
    end

    assign res_ch.valid        = res_valid_reg;
    assign res_ch.result_frame = res_data_reg.result_frame;
    assign res_ch.in_use       = res_data_reg.in_use;
    assign res_ch.status       = res_data_reg.status;
    assign res_ch.used_frames  = res_data_reg.used_frames;

`ifndef SYNTHESIS
    a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && res_ch.status == ST_NOFREE |-> res_ch.result_frame == '0 && res_ch.in_use)
        else $error("no-free result carries a frame");

    a_range_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && res_ch.status == ST_RANGE |-> res_ch.in_use)
        else $error("out-of-range result reports frame free");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid |-> res_ch.used_frames <= COUNT_W'(MAX_FRAMES))
        else $error("used frame count beyond capacity");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> !cmd_ch.ready)
        else $error("bitmap written while idle");
`endif

endmodule

>>> src/bfa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bfa_bitmap_ram
// Usage bitmap store: one write and one registered read port, with a valid
// bit per word so that unwritten words read as all free after reset.
// ----------------------------------------------------------------------------
module bfa_bitmap_ram import bfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfa_ram_req_t         req,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic [NUM_WORDS-1:0] valid_reg;
    logic                 rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rvalid_reg <= valid_reg[req.raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

>>> src/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Command sequencer: reads the bitmap word, modifies and writes it back,
// scans words one per cycle for allocate, and keeps the used-frame count.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [FRAME_W-1:0]   frame_index,
    input  logic [COUNT_W-1:0]   eff_count,
    input  logic                 slot_free,
    input  logic [WORD_BITS-1:0] rdata,
    output bfa_ram_req_t         ram_req,
    output bfa_ctrl_stat_t       stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [FRAME_W-1:0]    idx_reg, idx_next;
    logic [WORD_IDX_W-1:0] scan_reg, scan_next;
    logic [COUNT_W-1:0]    used_reg, used_next;
    bfa_result_t           result_reg, result_next;

    logic [BIT_IDX_W-1:0]  bit_sel;
    logic [WORD_BITS-1:0]  bit_mask;
    logic                  old_bit;
    logic [WORD_BITS-1:0]  mod_word;
    logic [BIT_IDX_W-1:0]  free_bit;
    logic [FRAME_W-1:0]    free_frame;
    logic [COUNT_W-1:0]    word_base;

    assign bit_sel    = idx_reg[BIT_IDX_W-1:0];
    assign bit_mask   = WORD_BITS'(1) << bit_sel;
    assign old_bit    = rdata[bit_sel];
    assign free_bit   = lowest_zero(rdata);
    assign free_frame = {scan_reg, free_bit};
    assign word_base  = {1'b0, scan_reg, {BIT_IDX_W{1'b0}}};

    always_comb
    begin
        case (cmd_reg)
            CMD_MARK_USED: mod_word = rdata | bit_mask;
            CMD_MARK_FREE: mod_word = rdata & ~bit_mask;
            default:       mod_word = rdata;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        scan_next   = scan_reg;
        used_next   = used_reg;
        result_next = result_reg;
        ram_req     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd;
                    idx_next    = frame_index;
                    scan_next   = '0;
                    ram_req.re  = 1'b1;
                    ram_req.raddr = (cmd == CMD_ALLOC) ? '0
                                  : frame_index[BIT_IDX_W +: WORD_IDX_W];
                    if (cmd != CMD_ALLOC && {1'b0, frame_index} >= eff_count)
                    begin
                        result_next = '{result_frame: frame_index, in_use: 1'b1,
                                        status: ST_RANGE, used_frames: used_reg};
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (cmd_reg != CMD_ALLOC)
                begin
                    ram_req.we    = (cmd_reg == CMD_MARK_USED) || (cmd_reg == CMD_MARK_FREE);
                    ram_req.waddr = idx_reg[BIT_IDX_W +: WORD_IDX_W];
                    ram_req.wdata = mod_word;
                    if (cmd_reg == CMD_MARK_USED && !old_bit)
                    begin
                        used_next = used_reg + COUNT_W'(1);
                    end
                    else if (cmd_reg == CMD_MARK_FREE && old_bit)
                    begin
                        used_next = used_reg - COUNT_W'(1);
                    end
                    result_next = '{result_frame: idx_reg, in_use: mod_word[bit_sel],
                                    status: ST_OK, used_frames: used_next};
                    state_next  = S_DONE;
                end
                else if (word_base >= eff_count)
                begin
                    result_next = '{result_frame: '0, in_use: 1'b1,
                                    status: ST_NOFREE, used_frames: used_reg};
                    state_next  = S_DONE;
                end
                else if (&rdata)
                begin
                    if (scan_reg == WORD_IDX_W'(NUM_WORDS - 1))
                    begin
                        result_next = '{result_frame: '0, in_use: 1'b1,
                                        status: ST_NOFREE, used_frames: used_reg};
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        scan_next     = scan_reg + WORD_IDX_W'(1);
                        ram_req.re    = 1'b1;
                        ram_req.raddr = scan_reg + WORD_IDX_W'(1);
                    end
                end
                else if ({1'b0, free_frame} >= eff_count)
                begin
                    result_next = '{result_frame: '0, in_use: 1'b1,
                                    status: ST_NOFREE, used_frames: used_reg};
                    state_next  = S_DONE;
                end
                else
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = scan_reg;
                    ram_req.wdata = rdata | (WORD_BITS'(1) << free_bit);
                    used_next     = used_reg + COUNT_W'(1);
                    result_next   = '{result_frame: free_frame, in_use: 1'b1,
                                      status: ST_OK, used_frames: used_next};
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        scan_reg   <= scan_next;
        result_reg <= result_next;
    end

    assign stat.idle   = (state_reg == S_IDLE);
    assign stat.done   = (state_reg == S_DONE);
    assign stat.result = result_reg;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap frame allocator. A short list of
// directed command words, some with hand-written results, is followed by
// random phases at several frame counts and idling patterns. Every accepted
// command word is run through a behavioral copy of the allocator, and each
// result word is compared field by field, in order, against it.
// ----------------------------------------------------------------------------
module tb;
    import bfa_pkg::*;

    typedef struct {
        bit                 is_cfg;
        logic [CMD_W-1:0]   op;
        logic [FRAME_W-1:0] idx;
        logic [COUNT_W-1:0] cfg_val;
        bit                 typed;
        bfa_result_t        want;
    } step_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bfa_cmd_if cmd_ch ();
    bfa_res_if res_ch ();

    bitmap_frame_allocator_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_ch  (cmd_ch),
        .res_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [MAX_FRAMES-1:0] frame_map;
    logic [COUNT_W-1:0]    frames_used;
    logic [COUNT_W-1:0]    frame_limit_reg;

    bfa_result_t pending_results[$];
    bfa_result_t want_word;
    bfa_result_t got_word;
    step_row_t   directed_rows[$];

    int mismatch_count;
    int words_sent;
    int settings_used;
    int nofree_count;
    int range_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #10ms;
        $display("Timeout with %0d result words outstanding", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic bfa_result_t predict_frame_op(input logic [CMD_W-1:0]   op,
                                                     input logic [FRAME_W-1:0] idx);
        bfa_result_t r;
        int          limit;
        int          f;
        limit = (frame_limit_reg > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit_reg);
        r.result_frame = idx;
        r.in_use = 1'b1;
        r.status = ST_OK;
        if (op == CMD_ALLOC)
        begin
            f = 0;
            while (f < limit && frame_map[f])
                f++;
            if (f < limit)
            begin
                frame_map[f] = 1'b1;
                frames_used++;
                r.result_frame = FRAME_W'(f);
            end
            else
            begin
                r.result_frame = '0;
                r.status = ST_NOFREE;
            end
        end
        else if (int'(idx) >= limit)
        begin
            r.status = ST_RANGE;
        end
        else
        begin
            if (op == CMD_MARK_USED && !frame_map[idx])
            begin
                frame_map[idx] = 1'b1;
                frames_used++;
            end
            else if (op == CMD_MARK_FREE && frame_map[idx])
            begin
                frame_map[idx] = 1'b0;
                frames_used--;
            end
            r.in_use = frame_map[idx];
        end
        r.used_frames = frames_used;
        return r;
    endfunction

    function automatic step_row_t cmd_row(input logic [CMD_W-1:0] op,
                                          input logic [FRAME_W-1:0] idx);
        step_row_t s;
        s.is_cfg = 1'b0;
        s.op = op;
        s.idx = idx;
        s.cfg_val = '0;
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic step_row_t chk_row(input logic [CMD_W-1:0]    op,
                                          input logic [FRAME_W-1:0]  idx,
                                          input logic [FRAME_W-1:0]  frame,
                                          input logic                in_use,
                                          input logic [STATUS_W-1:0] st,
                                          input logic [COUNT_W-1:0]  used);
        step_row_t s;
        s = cmd_row(op, idx);
        s.typed = 1'b1;
        s.want.result_frame = frame;
        s.want.in_use = in_use;
        s.want.status = st;
        s.want.used_frames = used;
        return s;
    endfunction

    function automatic step_row_t cfg_row(input logic [COUNT_W-1:0] val);
        step_row_t s;
        s = cmd_row(CMD_TEST, '0);
        s.is_cfg = 1'b1;
        s.cfg_val = val;
        return s;
    endfunction

    function automatic logic [FRAME_W-1:0] pick_index(input int limit);
        int sel;
        sel = $urandom_range(99);
        if (limit == 0 || sel < 10)
            return FRAME_W'($urandom);
        if (sel < 20)
            return (limit >= MAX_FRAMES || sel < 15) ? FRAME_W'(limit - 1) : FRAME_W'(limit);
        return FRAME_W'($urandom_range(limit - 1));
    endfunction

    function automatic logic [CMD_W-1:0] pick_op();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30)
            return CMD_ALLOC;
        if (sel < 50)
            return CMD_MARK_FREE;
        if (sel < 70)
            return CMD_MARK_USED;
        return CMD_TEST;
    endfunction

    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready = 1'b0;
        end
        else
        begin
            res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got_word.result_frame = res_ch.result_frame;
            got_word.in_use = res_ch.in_use;
            got_word.status = res_ch.status;
            got_word.used_frames = res_ch.used_frames;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result word frame=%0d in_use=%0d status=%0d used=%0d",
                             $realtime, got_word.result_frame, got_word.in_use,
                             got_word.status, got_word.used_frames);
            end
            else
            begin
                want_word = pending_results.pop_front();
                if (got_word.result_frame !== want_word.result_frame
                    || got_word.in_use !== want_word.in_use
                    || got_word.status !== want_word.status
                    || got_word.used_frames !== want_word.used_frames)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: exp frame=%0d in_use=%0d status=%0d used=%0d, got frame=%0d in_use=%0d status=%0d used=%0d",
                                 $realtime, want_word.result_frame, want_word.in_use,
                                 want_word.status, want_word.used_frames,
                                 got_word.result_frame, got_word.in_use,
                                 got_word.status, got_word.used_frames);
                end
            end
        end
    end

    // entered and left at a falling edge; valid stays up for a following word
    task automatic send_word(input logic [CMD_W-1:0] op, input logic [FRAME_W-1:0] idx,
                             input bit typed, input bfa_result_t typed_res);
        bfa_result_t r;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.cmd = op;
        cmd_ch.frame_index = idx;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        r = predict_frame_op(op, idx);
        if (typed)
            r = typed_res;
        if (r.status == ST_NOFREE)
            nofree_count++;
        if (r.status == ST_RANGE)
            range_count++;
        pending_results.push_back(r);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results(input int limit);
        int n;
        n = 0;
        cmd_ch.valid = 1'b0;
        while (pending_results.size() != 0 && n < limit)
        begin
            @(negedge clk);
            n++;
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = ADDR_FRAME_COUNT;
        pwdata = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        if (wr)
            frame_limit_reg = wdata[COUNT_W-1:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_frame_limit(input logic [COUNT_W-1:0] val);
        logic [APB_DATA_W-1:0] rd;
        drain_results(5000);
        apb_access(1'b1, APB_DATA_W'(val), rd);
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(val))
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: frame_count readback exp %0d got %0d", $realtime, val, rd);
        end
        settings_used++;
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
        endcase
    endtask

    initial
    begin
        logic [COUNT_W-1:0] phase_counts [9];
        int                 limit;
        step_row_t          row;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = CMD_MARK_USED;
        cmd_ch.frame_index = '0;
        res_ch.ready = 1'b0;
        frame_map = '0;
        frames_used = '0;
        frame_limit_reg = FRAME_COUNT_RST;
        mismatch_count = 0;
        words_sent = 0;
        settings_used = 0;
        nofree_count = 0;
        range_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        hold_left = 0;
        phase_counts = '{13'd64, 13'd4096, 13'd1, 13'd100, 13'd8191,
                         13'd4095, 13'd33, 13'd0, 13'd200};

        directed_rows.push_back(chk_row(CMD_TEST, 12'd0, 12'd0, 1'b0, ST_OK, 13'd0));
        directed_rows.push_back(chk_row(CMD_TEST, 12'd4095, 12'd4095, 1'b0, ST_OK, 13'd0));
        directed_rows.push_back(chk_row(CMD_ALLOC, 12'd77, 12'd0, 1'b1, ST_OK, 13'd1));
        directed_rows.push_back(chk_row(CMD_ALLOC, 12'd4095, 12'd1, 1'b1, ST_OK, 13'd2));
        directed_rows.push_back(chk_row(CMD_MARK_USED, 12'd4095, 12'd4095, 1'b1, ST_OK, 13'd3));
        directed_rows.push_back(chk_row(CMD_MARK_USED, 12'd4095, 12'd4095, 1'b1, ST_OK, 13'd3));
        directed_rows.push_back(chk_row(CMD_MARK_FREE, 12'd0, 12'd0, 1'b0, ST_OK, 13'd2));
        directed_rows.push_back(chk_row(CMD_MARK_FREE, 12'd0, 12'd0, 1'b0, ST_OK, 13'd2));
        directed_rows.push_back(chk_row(CMD_ALLOC, 12'd0, 12'd0, 1'b1, ST_OK, 13'd3));
        directed_rows.push_back(cmd_row(CMD_MARK_USED, 12'hAAA));
        directed_rows.push_back(cmd_row(CMD_TEST, 12'h555));
        directed_rows.push_back(cmd_row(CMD_MARK_FREE, 12'hAAA));
        directed_rows.push_back(cfg_row(13'd40));
        directed_rows.push_back(chk_row(CMD_TEST, 12'd4095, 12'd4095, 1'b1, ST_RANGE, 13'd3));
        directed_rows.push_back(chk_row(CMD_MARK_USED, 12'd40, 12'd40, 1'b1, ST_RANGE, 13'd3));
        directed_rows.push_back(chk_row(CMD_MARK_FREE, 12'd4095, 12'd4095, 1'b1, ST_RANGE, 13'd3));
        directed_rows.push_back(cmd_row(CMD_MARK_USED, 12'd39));
        directed_rows.push_back(cfg_row(13'd0));
        directed_rows.push_back(chk_row(CMD_ALLOC, 12'd5, 12'd0, 1'b1, ST_NOFREE, 13'd4));
        directed_rows.push_back(chk_row(CMD_TEST, 12'd0, 12'd0, 1'b1, ST_RANGE, 13'd4));
        directed_rows.push_back(cfg_row(13'd3));
        directed_rows.push_back(chk_row(CMD_ALLOC, 12'd0, 12'd2, 1'b1, ST_OK, 13'd5));
        directed_rows.push_back(chk_row(CMD_ALLOC, 12'd0, 12'd0, 1'b1, ST_NOFREE, 13'd5));
        directed_rows.push_back(cfg_row(13'd8191));
        directed_rows.push_back(chk_row(CMD_TEST, 12'd4095, 12'd4095, 1'b1, ST_OK, 13'd5));
        directed_rows.push_back(chk_row(CMD_ALLOC, 12'd0, 12'd3, 1'b1, ST_OK, 13'd6));
        directed_rows.push_back(cfg_row(13'd4095));
        directed_rows.push_back(chk_row(CMD_MARK_FREE, 12'd4095, 12'd4095, 1'b1, ST_RANGE, 13'd6));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
                set_frame_limit(row.cfg_val);
            else
                send_word(row.op, row.idx, row.typed, row.want);
        end

        foreach (phase_counts[p])
        begin
            set_frame_limit(phase_counts[p]);
            set_idling(p);
            limit = (frame_limit_reg > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit_reg);
            // stall the result side long enough to back up the command side
            if (p == 1)
                hold_req = 300;
            repeat (110)
                send_word(pick_op(), pick_index(limit), 1'b0, '0);
        end

        drain_results(20000);
        if (pending_results.size() != 0)
        begin
            mismatch_count += pending_results.size();
            $display("%0d result words never arrived", pending_results.size());
        end
        $display("Sent %0d command words across %0d frame-count settings",
                 words_sent, settings_used);
        $display("Saw %0d allocations with no free frame and %0d out-of-range indices",
                 nofree_count, range_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
